[rtl/teg_pkg.sv]
package teg_pkg;

   // verdict codes on the result channel
   typedef enum logic [2:0] {
      ENC_UTF8     = 3'd0,
      ENC_ANSI     = 3'd1,
      ENC_UTF8_BOM = 3'd2,
      ENC_UTF16_BE = 3'd3,
      ENC_UTF16_LE = 3'd4
   } encoding_type;

   // one request moving from the input register into the scanner
   typedef struct packed {
      logic       valid;
      logic [7:0] data;
      logic       last;
   } step_type;

   localparam int unsigned HEAD_DEPTH = 3;
   localparam logic [2:0]  POS_MAX    = 3'd7;

   // minimum file sizes for each byte order mark
   localparam logic [2:0]  UTF16_MIN_BYTES = 3'd3;
   localparam logic [2:0]  UTF8_MIN_BYTES  = 3'd4;

   // byte order mark bytes
   localparam logic [7:0]  BOM_FE = 8'hFE;
   localparam logic [7:0]  BOM_FF = 8'hFF;
   localparam logic [7:0]  BOM_EF = 8'hEF;
   localparam logic [7:0]  BOM_BB = 8'hBB;
   localparam logic [7:0]  BOM_BF = 8'hBF;

endpackage

[rtl/teg_scan.sv]
module teg_scan (
   input  logic                  clock,
   input  logic                  reset,
   input  teg_pkg::step_type     step,
   output teg_pkg::encoding_type verdict
);
   import teg_pkg::*;

   logic [2:0] pos_ff,     pos_in;
   logic [7:0] head_ff [HEAD_DEPTH];
   logic [7:0] head_in [HEAD_DEPTH];
   logic [1:0] pend_ff,    pend_in;
   logic       inv_ff,     inv_in;

   // byte counter and head capture
   always_comb begin
      for (int i = 0; i < HEAD_DEPTH; i++) begin
         head_in[i] = head_ff[i];
      end
      if (pos_ff < 3'(HEAD_DEPTH)) begin
         head_in[pos_ff[1:0]] = step.data;
      end
      pos_in = (pos_ff < POS_MAX) ? pos_ff + 3'd1 : pos_ff;
   end

   // loose utf-8 check, frozen once an error is seen
   always_comb begin
      pend_in = pend_ff;
      inv_in  = inv_ff;
      if (!inv_ff) begin
         if (pend_ff != 2'd0) begin
            if (step.data[7:6] != 2'b10) begin
               inv_in = 1'b1;
            end else begin
               pend_in = pend_ff - 2'd1;
            end
         end else begin
            priority if (step.data == 8'h00) begin
               inv_in = 1'b1;
            end else if (step.data[7] == 1'b0) begin
               pend_in = 2'd0;
            end else if (step.data[7:6] == 2'b10) begin
               inv_in = 1'b1;
            end else if (step.data[7:5] == 3'b110) begin
               pend_in = 2'd1;
            end else if (step.data[7:4] == 4'b1110) begin
               pend_in = 2'd2;
            end else if (step.data[7:3] == 5'b11110) begin
               pend_in = 2'd3;
            end else begin
               inv_in = 1'b1;
            end
         end
      end
   end

   // verdict from the state including this byte
   always_comb begin
      priority if (pos_in >= UTF16_MIN_BYTES && head_in[0] == BOM_FE &&
                   head_in[1] == BOM_FF) begin
         verdict = ENC_UTF16_BE;
      end else if (pos_in >= UTF16_MIN_BYTES && head_in[0] == BOM_FF &&
                   head_in[1] == BOM_FE) begin
         verdict = ENC_UTF16_LE;
      end else if (pos_in >= UTF8_MIN_BYTES && head_in[0] == BOM_EF &&
                   head_in[1] == BOM_BB && head_in[2] == BOM_BF) begin
         verdict = ENC_UTF8_BOM;
      end else if (inv_in || pend_in != 2'd0) begin
         verdict = ENC_ANSI;
      end else begin
         verdict = ENC_UTF8;
      end
   end

   // state registers, cleared on reset and after the last byte of a file
   always_ff @(posedge clock) begin
      if (reset || (step.valid && step.last)) begin
         pos_ff  <= '0;
         pend_ff <= '0;
         inv_ff  <= 1'b0;
         for (int i = 0; i < HEAD_DEPTH; i++) begin
            head_ff[i] <= '0;
         end
      end else if (step.valid) begin
         pos_ff  <= pos_in;
         pend_ff <= pend_in;
         inv_ff  <= inv_in;
         for (int i = 0; i < HEAD_DEPTH; i++) begin
            head_ff[i] <= head_in[i];
         end
      end
   end

endmodule

[rtl/text_encoding_guesser.sv]
// Text encoding guesser: takes a file one byte per request, the final byte
// flagged by req_last_byte, and returns exactly one verdict per file on
// rsp_encoding (0 utf-8, 1 ansi, 2 utf-8 with mark, 3 utf-16 big-endian mark,
// 4 utf-16 little-endian mark). Bytes are taken at one per clock cycle with no
// gaps between files unless a final byte waits for the result register; the
// per-byte state update is a small piece of logic between the input register
// and the result register, and each verdict passes through both registers.
// While a verdict waits under rsp_stall, further non-final bytes keep flowing;
// only the next file's final byte waits for the result register to free up.
module text_encoding_guesser (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_encoding
);
   import teg_pkg::*;

   logic         in_valid_ff;
   logic [7:0]   in_data_ff;
   logic         in_last_ff;
   logic         out_valid_ff;
   encoding_type out_enc_ff;
   logic         out_ready;
   logic         advance;
   step_type     step;
   encoding_type verdict;

   // pipeline control
   assign out_ready = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && (!in_last_ff || out_ready);
   assign req_stall = in_valid_ff && !advance;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         in_data_ff <= req_data_byte;
         in_last_ff <= req_last_byte;
      end
   end

   assign step = '{valid: advance, data: in_data_ff, last: in_last_ff};

   teg_scan u_scan (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .verdict (verdict)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance && in_last_ff) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_last_ff) begin
         out_enc_ff <= verdict;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_encoding = 3'(out_enc_ff);

endmodule

[rtl/teg_checker.sv]
module teg_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       req_last_byte,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [2:0] rsp_encoding
);
   import teg_pkg::*;

   // a waiting verdict holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_encoding))
      else $error("stalled verdict changed");

   // only defined verdict codes leave the block
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_encoding == 3'(ENC_UTF8) || rsp_encoding == 3'(ENC_ANSI) ||
                     rsp_encoding == 3'(ENC_UTF8_BOM) ||
                     rsp_encoding == 3'(ENC_UTF16_BE) ||
                     rsp_encoding == 3'(ENC_UTF16_LE)))
      else $error("undefined verdict code");

   // a fresh verdict follows an accepted final byte
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall && req_last_byte, 2))
      else $error("verdict without a final byte");

   // with an empty result register requests are never held off
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("request stalled with empty result register");

endmodule

bind text_encoding_guesser teg_checker u_teg_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .req_last_byte (req_last_byte),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_encoding  (rsp_encoding)
);

[bench/text_encoding_guesser_tb.sv]
`timescale 1ns / 100ps

module text_encoding_guesser_tb;
   import teg_pkg::*;

   localparam int TARGET_BYTES = 2000;
   localparam int IDLE_PERCENT = 37;
   localparam int HOLD_CYCLES  = 200;
   localparam int DRAIN_CYCLES = 10;
   localparam int LIMIT_CYCLES = 400000;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_data_byte = 8'h00;
   logic       req_last_byte = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [2:0] rsp_encoding;

   text_encoding_guesser DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_encoding  (rsp_encoding)
   );

   // guesser state as seen by the scoreboard
   logic [2:0]   file_len;
   logic [7:0]   head_seen [0:2];
   logic [1:0]   cont_left;
   logic         utf8_broken;
   encoding_type expected_verdicts [$];

   logic [7:0] file_bytes [$];
   int         errors = 0;
   int         bytes_sent = 0;
   int         files_sent = 0;
   int         verdict_count [0:4] = '{default: 0};
   int         cycles = 0;
   bit         idle_on = 1'b1;
   bit         hold_rsp = 1'b0;
   event       hold_start;

   always #5 clock = ~clock;

   function automatic bit roll_idle();
      return idle_on && ($urandom_range(0, 99) < IDLE_PERCENT);
   endfunction

   // loose utf-8 scan plus mark detection, one verdict per final byte
   task automatic predict_byte(input logic [7:0] b, input logic last);
      encoding_type verdict;
      if (file_len < 3'd3) head_seen[file_len[1:0]] = b;
      if (file_len != POS_MAX) file_len = file_len + 3'd1;
      if (!utf8_broken) begin
         if (cont_left != 2'd0) begin
            if (b[7:6] != 2'b10) utf8_broken = 1'b1;
            else cont_left = cont_left - 2'd1;
         end else if (b == 8'h00) begin
            utf8_broken = 1'b1;
         end else if (!b[7]) begin
            // plain 7-bit character
         end else if (b[7:6] == 2'b10) begin
            utf8_broken = 1'b1;
         end else if (b[7:5] == 3'b110) begin
            cont_left = 2'd1;
         end else if (b[7:4] == 4'b1110) begin
            cont_left = 2'd2;
         end else if (b[7:3] == 5'b11110) begin
            cont_left = 2'd3;
         end else begin
            utf8_broken = 1'b1;
         end
      end
      bytes_sent++;
      if (last) begin
         if (file_len >= UTF16_MIN_BYTES && head_seen[0] == BOM_FE && head_seen[1] == BOM_FF)
            verdict = ENC_UTF16_BE;
         else if (file_len >= UTF16_MIN_BYTES && head_seen[0] == BOM_FF &&
                  head_seen[1] == BOM_FE)
            verdict = ENC_UTF16_LE;
         else if (file_len >= UTF8_MIN_BYTES && head_seen[0] == BOM_EF &&
                  head_seen[1] == BOM_BB && head_seen[2] == BOM_BF)
            verdict = ENC_UTF8_BOM;
         else if (utf8_broken || cont_left != 2'd0)
            verdict = ENC_ANSI;
         else
            verdict = ENC_UTF8;
         expected_verdicts = {expected_verdicts, verdict};
         files_sent++;
         file_len = 3'd0;
         head_seen = '{8'h00, 8'h00, 8'h00};
         cont_left = 2'd0;
         utf8_broken = 1'b0;
      end
   endtask

   // offer one request, hold it until taken, then log it with the predictor
   task automatic send_byte(input logic [7:0] b, input logic last);
      @(negedge clock);
      while (roll_idle()) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      req_last_byte <= last;
      do @(posedge clock); while (req_stall);
      predict_byte(b, last);
   endtask

   task automatic send_file();
      for (int i = 0; i < file_bytes.size(); i++)
         send_byte(file_bytes[i], i == file_bytes.size() - 1);
   endtask

   // one utf-8 character of 1 to 4 bytes that the loose check accepts
   task automatic append_char();
      int n;
      n = $urandom_range(1, 4);
      case (n)
         1: file_bytes = {file_bytes, 8'($urandom_range(1, 127))};
         2: file_bytes = {file_bytes, 8'(8'hC0 | $urandom_range(0, 31))};
         3: file_bytes = {file_bytes, 8'(8'hE0 | $urandom_range(0, 15))};
         default: file_bytes = {file_bytes, 8'(8'hF0 | $urandom_range(0, 7))};
      endcase
      for (int i = 1; i < n; i++)
         file_bytes = {file_bytes, 8'(8'h80 | $urandom_range(0, 63))};
   endtask

   // mostly well-formed files, some with marks, some broken, some pure noise
   task automatic make_random_file();
      int kind;
      int nchars;
      int pos;
      file_bytes.delete();
      kind = $urandom_range(0, 99);
      if (kind < 20) begin
         case ($urandom_range(0, 4))
            0: file_bytes = '{BOM_FE, BOM_FF};
            1: file_bytes = '{BOM_FF, BOM_FE};
            2: file_bytes = '{BOM_EF, BOM_BB, BOM_BF};
            3: file_bytes = '{BOM_FE, BOM_FE};
            default: file_bytes = '{BOM_EF, BOM_BB, 8'h41};
         endcase
         nchars = $urandom_range(0, 4);
      end else begin
         nchars = $urandom_range(1, 6);
      end
      if ($urandom_range(0, 19) == 0) nchars += 10;
      for (int i = 0; i < nchars; i++) append_char();
      if (kind >= 20 && kind < 35) begin
         // raw noise
         file_bytes.delete();
         nchars = $urandom_range(1, 8);
         for (int i = 0; i < nchars; i++)
            file_bytes = {file_bytes, 8'($urandom_range(0, 255))};
      end else if (kind >= 35 && kind < 60 && file_bytes.size() > 0) begin
         // one defect somewhere in an otherwise clean file
         pos = $urandom_range(0, file_bytes.size() - 1);
         case ($urandom_range(0, 3))
            0: file_bytes[pos] = 8'h00;
            1: file_bytes[pos] = 8'(8'h80 | $urandom_range(0, 63));
            2: file_bytes[pos] = 8'(8'hF8 | $urandom_range(0, 7));
            default: void'(file_bytes.pop_back());
         endcase
      end
      if (file_bytes.size() == 0) file_bytes = {file_bytes, 8'($urandom_range(0, 255))};
   endtask

   // byte order marks, each long enough to count
   task automatic test_marks();
      file_bytes = '{8'hFE, 8'hFF, 8'h41};
      send_file();
      file_bytes = '{8'hFF, 8'hFE, 8'h00};
      send_file();
      file_bytes = '{8'hEF, 8'hBB, 8'hBF, 8'h41};
      send_file();
   endtask

   // marks too short to count fall back to the utf-8 scan
   task automatic test_short_files();
      file_bytes = '{8'hFE, 8'hFF};
      send_file();
      file_bytes = '{8'hEF, 8'hBB, 8'hBF};
      send_file();
   endtask

   // each way the utf-8 scan can fail, plus clean extremes
   task automatic test_invalid_bytes();
      file_bytes = '{8'h00};
      send_file();
      file_bytes = '{8'h80};
      send_file();
      file_bytes = '{8'hC3, 8'h41};
      send_file();
      file_bytes = '{8'hE2, 8'h82};
      send_file();
      file_bytes = '{8'hF0, 8'h9F, 8'h98, 8'h80};
      send_file();
      file_bytes = '{8'hF8};
      send_file();
      file_bytes = '{8'h7F};
      send_file();
   endtask

   task automatic test_random_files();
      while (bytes_sent < TARGET_BYTES) begin
         make_random_file();
         send_file();
      end
   endtask

   // back-to-back requests and results with no gaps at all
   task automatic test_no_idle_burst();
      int burst_end;
      idle_on = 1'b0;
      burst_end = bytes_sent + 200;
      while (bytes_sent < burst_end) begin
         make_random_file();
         send_file();
      end
      idle_on = 1'b1;
   endtask

   // results held off for a long time while short files keep coming
   task automatic test_backpressure();
      -> hold_start;
      for (int i = 0; i < 40; i++) begin
         file_bytes.delete();
         append_char();
         if ($urandom_range(0, 1)) append_char();
         send_file();
      end
   endtask

   // long receiver hold-off, timed in its own process
   always begin
      @(hold_start);
      @(posedge clock);
      hold_rsp = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_rsp = 1'b0;
   end

   // receiver stall
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= hold_rsp || roll_idle();
      end
   end

   // compare each verdict with the oldest expected one
   always @(posedge clock) begin : check_verdicts
      encoding_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_verdicts.size() == 0) begin
            $display("%0t: unexpected verdict, expected none actual %0d",
                     $time, rsp_encoding);
            errors++;
         end else begin
            want = expected_verdicts.pop_front();
            if (rsp_encoding !== want) begin
               $display("%0t: encoding mismatch, expected %0d actual %0d",
                        $time, want, rsp_encoding);
               errors++;
            end
         end
         if (rsp_encoding <= 3'd4) verdict_count[rsp_encoding]++;
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles == LIMIT_CYCLES) begin
         $display("%0t: timeout with %0d verdicts outstanding",
                  $time, expected_verdicts.size());
         $display("FAILED: results differ");
         $finish;
      end
   end

   initial begin
      file_len = 3'd0;
      head_seen = '{8'h00, 8'h00, 8'h00};
      cont_left = 2'd0;
      utf8_broken = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_marks();
      test_short_files();
      test_invalid_bytes();
      test_no_idle_burst();
      test_backpressure();
      test_random_files();

      @(negedge clock);
      req_valid     <= 1'b0;
      req_last_byte <= 1'b0;
      while (expected_verdicts.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run covered %0d bytes in %0d files, %0d mismatches", bytes_sent,
               files_sent, errors);
      $display("verdicts seen: utf8 %0d, ansi %0d, utf8 mark %0d, utf16 be %0d, utf16 le %0d",
               verdict_count[0], verdict_count[1], verdict_count[2], verdict_count[3],
               verdict_count[4]);
      if (errors == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/teg_pkg.sv
rtl/teg_scan.sv
rtl/text_encoding_guesser.sv
rtl/teg_checker.sv
bench/text_encoding_guesser_tb.sv
